/* rtl/sprnv_pkg.sv */
package sprnv_pkg;

    // Display and chroma plane geometry.
    localparam int DISPLAY_WIDTH        = 320;
    localparam int DISPLAY_HEIGHT       = 240;
    localparam int CHROMA_SOURCE_WIDTH  = 320;
    localparam int CHROMA_SOURCE_HEIGHT = 240;

    // Field widths.
    localparam int COMP_W      = 8;
    localparam int COORD_W     = 10;
    localparam int COUNT_W     = 9;
    localparam int LUMA_ADDR_W = 17;
    localparam int CHROMA_IX_W = 15;
    localparam int CFG_IX_W    = 2;

    // The display column can reach 1023 + 511, and the row can go from -511 to 1534.
    localparam int PX_W = COORD_W + 1;
    localparam int PY_W = COORD_W + 2;

    // Wide enough for any geometry up to 1024 by 1024, before masking to the field.
    localparam int LUMA_CALC_W   = 2 * COORD_W;
    localparam int CHROMA_CALC_W = 2 * COORD_W - 2;

    // Largest sprite size that is honored.
    localparam logic [COORD_W-1:0] SIZE_MAX = COORD_W'(512);

    // Transparent color key level, equal on all three components.
    localparam logic [COMP_W-1:0] KEY_LEVEL = 8'h80;

    // Luma range in studio swing.
    localparam logic [COMP_W:0] LUMA_LO = 9'd16;
    localparam logic [COMP_W:0] LUMA_HI = 9'd235;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_DEST_X        = 2'd0,
        CFG_DEST_Y        = 2'd1,
        CFG_SPRITE_WIDTH  = 2'd2,
        CFG_SPRITE_HEIGHT = 2'd3
    } t_cfg_index;

    // Effective sprite size: zero acts as one, large values saturate.
    function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v == '0) begin
            res = COORD_W'(1);
        end else if (v > SIZE_MAX) begin
            res = SIZE_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* rtl/sprite_rgb_to_nv21_blit_unit.sv */
// Channel   Direction  Handshake             Payload
// pixel     in         i_valid / o_stall     i_red, i_green, i_blue
// result    out        o_valid / i_stall     o_luma_*, o_chroma_*, o_cr/cb_value, o_last_pixel
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel is accepted per clock while o_stall is low. Each result passes through
// the pixel register, which holds the placed coordinates, and then the result
// register; the color conversion and address multiply sit between them.
// Reset (synchronous, active low) clears the counters and the valid flags and sets
// the configuration registers to their power-up values. A held i_stall fills both
// registers, after which o_stall rises; the configuration port is always ready.
module sprite_rgb_to_nv21_blit_unit
    import sprnv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Pixel input channel.
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COMP_W-1:0]      i_red,
    input  logic [COMP_W-1:0]      i_green,
    input  logic [COMP_W-1:0]      i_blue,
    // Result output channel.
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_luma_write,
    output logic [LUMA_ADDR_W-1:0] o_luma_address,
    output logic [COMP_W-1:0]      o_luma_value,
    output logic                   o_chroma_write,
    output logic [CHROMA_IX_W-1:0] o_chroma_index,
    output logic [COMP_W-1:0]      o_cr_value,
    output logic [COMP_W-1:0]      o_cb_value,
    output logic                   o_last_pixel,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IX_W-1:0]    i_cfg_index,
    input  logic [COORD_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [COORD_W-1:0] r_dest_x, r_dest_y, r_sprite_width, r_sprite_height;

    // Sprite position counters.
    logic [COUNT_W-1:0] r_column_count, n_column_count;
    logic [COUNT_W-1:0] r_file_row_count, n_file_row_count;

    // Pixel register stage.
    logic                   r_s1_valid;
    logic [COMP_W-1:0]      r_s1_red, r_s1_green, r_s1_blue;
    logic [PX_W-1:0]        r_s1_px;
    logic signed [PY_W-1:0] r_s1_py;
    logic                   r_s1_last;

    // Result register stage.
    logic                   r_out_valid;
    logic                   r_luma_write;
    logic [LUMA_ADDR_W-1:0] r_luma_address;
    logic [COMP_W-1:0]      r_luma_value;
    logic                   r_chroma_write;
    logic [CHROMA_IX_W-1:0] r_chroma_index;
    logic [COMP_W-1:0]      r_cr_value;
    logic [COMP_W-1:0]      r_cb_value;
    logic                   r_last_pixel;

    logic out_load, s1_load, in_accept;

    // Pipeline advance: each stage moves when the one after it has room.
    assign out_load  = !r_out_valid || !i_stall;
    assign s1_load   = !r_s1_valid || out_load;
    assign o_stall   = !s1_load;
    assign in_accept = i_valid && s1_load;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x        <= '0;
            r_dest_y        <= '0;
            r_sprite_width  <= COORD_W'(16);
            r_sprite_height <= COORD_W'(32);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEST_X:        r_dest_x        <= i_cfg_data;
                CFG_DEST_Y:        r_dest_y        <= i_cfg_data;
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data;
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data;
                default:           r_dest_x        <= r_dest_x;
            endcase
        end
    end

    // Placement of the incoming pixel and the next counter values.
    logic [COORD_W-1:0]     eff_w, eff_h;
    logic                   end_col, end_row;
    logic [PX_W-1:0]        s0_px;
    logic signed [PY_W-1:0] s0_py;

    always_comb begin
        eff_w   = eff_size(r_sprite_width);
        eff_h   = eff_size(r_sprite_height);
        end_col = (COORD_W'(r_column_count) + COORD_W'(1)) >= eff_w;
        end_row = (COORD_W'(r_file_row_count) + COORD_W'(1)) >= eff_h;
        s0_px   = PX_W'(r_dest_x) + PX_W'(r_column_count);
        s0_py   = $signed(PY_W'(r_dest_y)) + $signed(PY_W'(eff_h)) - $signed(PY_W'(1))
                  - $signed(PY_W'(r_file_row_count));
        if (end_col) begin
            n_column_count   = '0;
            n_file_row_count = end_row ? '0 : r_file_row_count + COUNT_W'(1);
        end else begin
            n_column_count   = r_column_count + COUNT_W'(1);
            n_file_row_count = r_file_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count   <= '0;
            r_file_row_count <= '0;
        end else if (in_accept) begin
            r_column_count   <= n_column_count;
            r_file_row_count <= n_file_row_count;
        end
    end

    // Pixel register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_px    <= s0_px;
            r_s1_py    <= s0_py;
            r_s1_last  <= end_col && end_row;
        end
    end

    // Color conversion, visibility tests and address arithmetic.
    logic                     is_key, luma_on, chroma_on;
    logic [2*COMP_W-1:0]      luma_sum;
    logic [COMP_W:0]          luma_raw, luma_clamped;
    logic signed [17:0]       cb_sum, cr_sum;
    logic [9:0]               cb_raw, cr_raw;
    logic [COMP_W-1:0]        cb_clamped, cr_clamped;
    logic [LUMA_CALC_W-1:0]   luma_addr_full;
    logic [CHROMA_CALC_W-1:0] chroma_ix_full;

    always_comb begin
        is_key = (r_s1_red == KEY_LEVEL) && (r_s1_green == KEY_LEVEL)
                 && (r_s1_blue == KEY_LEVEL);

        luma_sum = 16'(r_s1_red) * 16'd77 + 16'(r_s1_green) * 16'd150
                   + 16'(r_s1_blue) * 16'd29 + 16'd128;
        luma_raw = 9'(luma_sum[2*COMP_W-1:COMP_W]) + LUMA_LO;
        luma_clamped = (luma_raw > LUMA_HI) ? LUMA_HI : luma_raw;

        // The 128 offset is folded in before the shift, so the sums stay positive.
        cb_sum = -18'sd43 * $signed({10'd0, r_s1_red}) - 18'sd84 * $signed({10'd0, r_s1_green})
                 + 18'sd127 * $signed({10'd0, r_s1_blue}) + 18'sd32896;
        cr_sum = 18'sd127 * $signed({10'd0, r_s1_red}) - 18'sd106 * $signed({10'd0, r_s1_green})
                 - 18'sd21 * $signed({10'd0, r_s1_blue}) + 18'sd32896;
        cb_raw = cb_sum[17:8];
        cr_raw = cr_sum[17:8];
        cb_clamped = cb_raw[9] ? '0 : (cb_raw[8] ? 8'hFF : cb_raw[7:0]);
        cr_clamped = cr_raw[9] ? '0 : (cr_raw[8] ? 8'hFF : cr_raw[7:0]);

        luma_on = !r_s1_py[PY_W-1]
                  && (r_s1_px < PX_W'(DISPLAY_WIDTH))
                  && (r_s1_py[PY_W-2:0] < (PY_W-1)'(DISPLAY_HEIGHT));
        chroma_on = !r_s1_py[PY_W-1] && !r_s1_px[0] && !r_s1_py[0]
                    && (r_s1_px[PX_W-1:1] < (PX_W-1)'(CHROMA_SOURCE_WIDTH / 2))
                    && (r_s1_py[PY_W-2:1] < (PY_W-2)'(CHROMA_SOURCE_HEIGHT / 2));

        luma_addr_full = LUMA_CALC_W'(r_s1_py[COORD_W-1:0]) * LUMA_CALC_W'(DISPLAY_WIDTH)
                         + LUMA_CALC_W'(r_s1_px[COORD_W-1:0]);
        chroma_ix_full = CHROMA_CALC_W'(r_s1_py[COORD_W-1:1])
                         * CHROMA_CALC_W'(CHROMA_SOURCE_WIDTH / 2)
                         + CHROMA_CALC_W'(r_s1_px[COORD_W-1:1]);
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_last_pixel <= r_s1_last;
            if (!is_key && luma_on) begin
                r_luma_write   <= 1'b1;
                r_luma_address <= luma_addr_full[LUMA_ADDR_W-1:0];
                r_luma_value   <= luma_clamped[COMP_W-1:0];
            end else begin
                r_luma_write   <= 1'b0;
                r_luma_address <= '0;
                r_luma_value   <= '0;
            end
            if (!is_key && chroma_on) begin
                r_chroma_write <= 1'b1;
                r_chroma_index <= chroma_ix_full[CHROMA_IX_W-1:0];
                r_cr_value     <= cr_clamped;
                r_cb_value     <= cb_clamped;
            end else begin
                r_chroma_write <= 1'b0;
                r_chroma_index <= '0;
                r_cr_value     <= '0;
                r_cb_value     <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_luma_write   = r_luma_write;
    assign o_luma_address = r_luma_address;
    assign o_luma_value   = r_luma_value;
    assign o_chroma_write = r_chroma_write;
    assign o_chroma_index = r_chroma_index;
    assign o_cr_value     = r_cr_value;
    assign o_cb_value     = r_cb_value;
    assign o_last_pixel   = r_last_pixel;

endmodule
